// ----- rtl/core/irb_pkg.sv -----
// ----------------------------------------------------------------------------
// irb_pkg
// Shared constants and types for the interpolated ring buffer read block.
// ----------------------------------------------------------------------------
package irb_pkg;

  localparam int BUFFER_DEPTH = 4096;
  localparam int SAMPLE_BITS  = 24;
  localparam int FRAC_BITS    = 16;
  localparam int CNT_W        = 32;
  localparam int ADDR_W       = $clog2(BUFFER_DEPTH);

  localparam int ONE          = 1 << FRAC_BITS;
  localparam int HALF         = 1 << (FRAC_BITS - 1);
  // interpolate only while 1 - frac > 0.01
  localparam int INTERP_LIM   = ONE / 100;

  localparam int COEF_W       = SAMPLE_BITS + 4;
  localparam int T_W          = SAMPLE_BITS + 8;
  localparam int X_W          = FRAC_BITS + 1;
  localparam int PROD_W       = T_W + X_W;
  localparam int SUM_W        = PROD_W + 1;
  localparam int RES_W        = T_W + 1;

  typedef enum logic [2:0] {
    MODE_WRITE   = 3'd0,
    MODE_NEAREST = 3'd1,
    MODE_LINEAR  = 3'd2,
    MODE_CUBIC   = 3'd3,
    MODE_INVALID = 3'd4
  } read_mode_e;

endpackage

// ----- rtl/core/irb_ram.sv -----
// ----------------------------------------------------------------------------
// irb_ram
// Generic single-port RAM, one write or read per cycle, registered read.
// ----------------------------------------------------------------------------
module irb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/interpolated_ring_buffer_read_top.sv -----
// ----------------------------------------------------------------------------
// interpolated_ring_buffer_read_top
// Sample history ring addressed by absolute sample number, with nearest,
// linear and four-point Catmull-Rom reads through one shared multiplier.
//
//   channel  | handshake          | fields
//   ---------+--------------------+-------------------------------------------
//   command  | start, busy        | action_i, sample_in_i, position_whole_i,
//            |                    | position_frac_i
//   result   | done_o (strobe)    | sample_out_o, read_mode_o
//
// Write: ST_WRITE. Read: ST_BASE, ST_FETCH, ST_DECIDE (nearest/invalid end
// here), then ST_COEF for cubic only. The single RAM port fetches the four
// neighbors one per cycle, then the shared multiplier runs once (linear) or
// three times (cubic), each pass a multiply step and an add/shift step.
// Reset clears the sample count and the sequencer; history content is
// undefined until written. The result is a one-cycle strobe; no stall.
// ----------------------------------------------------------------------------
module interpolated_ring_buffer_read_top
  import irb_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          action_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  input  logic [CNT_W-1:0]              position_whole_i,
  input  logic [FRAC_BITS-1:0]          position_frac_i,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o,
  output logic [2:0]                    read_mode_o,
  output logic                          done_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_WRITE, ST_BASE, ST_FETCH, ST_DECIDE, ST_COEF, ST_MUL, ST_ADD
  } state_e;

  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  state_e                         state_q;
  logic [CNT_W-1:0]               wc_q;
  logic                           wrapped_q;
  logic [CNT_W-1:0]               p_q;
  logic [FRAC_BITS-1:0]           x_q;
  logic signed [SAMPLE_BITS-1:0]  wdata_q;
  logic [CNT_W-1:0]               base_q;
  logic [1:0]                     idx_q;
  logic signed [SAMPLE_BITS-1:0]  y_q [4];
  logic [3:0]                     valid_q;
  logic signed [COEF_W-1:0]       c1_q, c2_q, c3_q;
  logic                           lin_q;
  logic [1:0]                     step_q;
  logic signed [PROD_W-1:0]       prod_q;
  logic signed [T_W-1:0]          t_q;
  logic                           done_q;
  logic signed [SAMPLE_BITS-1:0]  sample_out_q;
  read_mode_e                     read_mode_q;

  logic                           ram_we;
  logic [ADDR_W-1:0]              ram_addr;
  logic [SAMPLE_BITS-1:0]         ram_rdata;

  irb_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (BUFFER_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (wdata_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    ram_we   = 1'b0;
    ram_addr = p_q[ADDR_W-1:0] + ADDR_W'(idx_q);
    unique case (state_q)
      ST_WRITE: begin
        ram_we   = 1'b1;
        ram_addr = wc_q[ADDR_W-1:0];
      end
      ST_BASE: begin
        ram_addr = p_q[ADDR_W-1:0] - ADDR_W'(1);
      end
      default: begin
      end
    endcase
  end

  // position validity: distance back from the newest sample below fill level
  logic [CNT_W-1:0] back;
  logic [CNT_W-1:0] avail;
  logic             pos_ok;

  always_comb begin
    back   = base_q + CNT_W'(1) - CNT_W'(idx_q);
    avail  = (wrapped_q || (wc_q >= CNT_W'(BUFFER_DEPTH))) ? CNT_W'(BUFFER_DEPTH) : wc_q;
    pos_ok = back < avail;
  end

  // read decision
  logic [X_W-1:0] one_minus_x;
  logic           interp;
  logic           use_cubic;
  logic           use_linear;

  always_comb begin
    one_minus_x = X_W'(ONE) - {1'b0, x_q};
    interp      = (x_q != '0) && (one_minus_x > X_W'(INTERP_LIM));
    use_cubic   = interp && (&valid_q);
    use_linear  = interp && valid_q[1] && valid_q[2];
  end

  // coefficients
  logic signed [COEF_W-1:0] e0, e1, e2, e3;
  logic signed [COEF_W-1:0] c1_d, c2_d, c3_d;

  always_comb begin
    e0   = COEF_W'(y_q[0]);
    e1   = COEF_W'(y_q[1]);
    e2   = COEF_W'(y_q[2]);
    e3   = COEF_W'(y_q[3]);
    c1_d = e2 - e0;
    c2_d = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
    c3_d = (e3 - e0) + ((e1 - e2) <<< 1) + (e1 - e2);
  end

  // shared multiply / add-shift unit
  logic signed [T_W-1:0]    mul_a;
  logic signed [X_W-1:0]    x_s;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [SUM_W-1:0]  bias;
  logic signed [SUM_W-1:0]  sum;
  logic                     last_step;
  logic signed [T_W-1:0]    t_d;
  logic signed [RES_W-1:0]  res;
  logic signed [SAMPLE_BITS-1:0] res_sat;

  always_comb begin
    mul_a  = (step_q == 2'd0) ? T_W'(c3_q) : t_q;
    x_s    = $signed({1'b0, x_q});
    prod_d = mul_a * x_s;
    if (lin_q) begin
      bias = SUM_W'(HALF);
    end else begin
      case (step_q)
        2'd0:    bias = SUM_W'(c2_q) <<< FRAC_BITS;
        2'd1:    bias = SUM_W'(c1_q) <<< FRAC_BITS;
        default: bias = SUM_W'(ONE);
      endcase
    end
    sum       = SUM_W'(prod_q) + bias;
    last_step = lin_q || (step_q == 2'd2);
    if (last_step && !lin_q) begin
      t_d = T_W'(sum >>> (FRAC_BITS + 1));
    end else begin
      t_d = T_W'(sum >>> FRAC_BITS);
    end
    res = RES_W'(y_q[1]) + RES_W'(t_d);
    if (res > RES_W'(S_MAX)) begin
      res_sat = S_MAX;
    end else if (res < RES_W'(S_MIN)) begin
      res_sat = S_MIN;
    end else begin
      res_sat = res[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      wc_q         <= '0;
      wrapped_q    <= 1'b0;
      p_q          <= '0;
      x_q          <= '0;
      wdata_q      <= '0;
      base_q       <= '0;
      idx_q        <= '0;
      y_q          <= '{default: '0};
      valid_q      <= '0;
      c1_q         <= '0;
      c2_q         <= '0;
      c3_q         <= '0;
      lin_q        <= 1'b0;
      step_q       <= '0;
      prod_q       <= '0;
      t_q          <= '0;
      done_q       <= 1'b0;
      sample_out_q <= '0;
      read_mode_q  <= MODE_WRITE;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          done_q <= 1'b0;
          if (start) begin
            p_q     <= position_whole_i;
            x_q     <= position_frac_i;
            wdata_q <= sample_in_i;
            state_q <= action_i ? ST_BASE : ST_WRITE;
          end
        end
        ST_WRITE: begin
          wc_q <= wc_q + CNT_W'(1);
          if (wc_q == '1) begin
            wrapped_q <= 1'b1;
          end
          done_q       <= 1'b1;
          sample_out_q <= '0;
          read_mode_q  <= MODE_WRITE;
          state_q      <= ST_IDLE;
        end
        ST_BASE: begin
          base_q  <= wc_q - CNT_W'(1) - p_q;
          idx_q   <= '0;
          state_q <= ST_FETCH;
        end
        ST_FETCH: begin
          y_q[idx_q]     <= ram_rdata;
          valid_q[idx_q] <= pos_ok;
          idx_q          <= idx_q + 2'd1;
          if (idx_q == 2'd3) begin
            state_q <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          step_q <= '0;
          if (use_cubic) begin
            lin_q   <= 1'b0;
            state_q <= ST_COEF;
          end else if (use_linear) begin
            lin_q   <= 1'b1;
            c3_q    <= COEF_W'(y_q[2]) - COEF_W'(y_q[1]);
            state_q <= ST_MUL;
          end else begin
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
            if (x_q[FRAC_BITS-1] ? valid_q[2] : valid_q[1]) begin
              sample_out_q <= x_q[FRAC_BITS-1] ? y_q[2] : y_q[1];
              read_mode_q  <= MODE_NEAREST;
            end else begin
              sample_out_q <= '0;
              read_mode_q  <= MODE_INVALID;
            end
          end
        end
        ST_COEF: begin
          c1_q    <= c1_d;
          c2_q    <= c2_d;
          c3_q    <= c3_d;
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          prod_q  <= prod_d;
          state_q <= ST_ADD;
        end
        ST_ADD: begin
          t_q <= t_d;
          if (last_step) begin
            done_q       <= 1'b1;
            sample_out_q <= res_sat;
            read_mode_q  <= lin_q ? MODE_LINEAR : MODE_CUBIC;
            state_q      <= ST_IDLE;
          end else begin
            step_q  <= step_q + 2'd1;
            state_q <= ST_MUL;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy         = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign sample_out_o = sample_out_q;
  assign read_mode_o  = read_mode_q;

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_write_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && read_mode_o == MODE_WRITE) |-> (wc_q == $past(wc_q) + CNT_W'(1)))
    else $error("write did not advance sample count");

  a_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (read_mode_o == MODE_WRITE || read_mode_o == MODE_INVALID))
      |-> (sample_out_o == '0))
    else $error("write or invalid read returned nonzero sample");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while sequencer busy");
`endif

endmodule

// ----- test/interpolated_ring_buffer_read_top_tb.sv -----
// ----------------------------------------------------------------------------
// interpolated_ring_buffer_read_top_tb
// Drives append and fractional-read transactions into the sample history and
// compares every result strobe against a cycle-free predictor of the ring,
// covering empty and partly filled history, boundary positions, all read
// modes, saturation and random traffic with and without sender idling.
// ----------------------------------------------------------------------------
module interpolated_ring_buffer_read_top_tb;
  import irb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TIMEOUT_CYCLES   = 1_000_000;
  localparam int DRAIN_CYCLES     = 32;
  localparam int LAST_INTERP_FRAC = ONE - INTERP_LIM - 1;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] sample;
    read_mode_e                    mode;
  } history_result_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic                          action_i = 1'b0;
  logic signed [SAMPLE_BITS-1:0] sample_in_i = '0;
  logic [CNT_W-1:0]              position_whole_i = '0;
  logic [FRAC_BITS-1:0]          position_frac_i = '0;
  logic signed [SAMPLE_BITS-1:0] sample_out_o;
  logic [2:0]                    read_mode_o;
  logic                          done_o;

  // predictor state
  logic signed [SAMPLE_BITS-1:0] sample_history [BUFFER_DEPTH];
  logic [CNT_W-1:0]              written_count = '0;
  logic [ADDR_W-1:0]             head_slot = '0;
  bit                            count_wrapped = 1'b0;

  history_result_t predicted_results [$];
  history_result_t oldest_result;
  int mode_hits [0:4] = '{default: 0};
  int results_seen = 0;
  int fail_count = 0;
  int cycle_count = 0;

  interpolated_ring_buffer_read_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .action_i        (action_i),
    .sample_in_i     (sample_in_i),
    .position_whole_i(position_whole_i),
    .position_frac_i (position_frac_i),
    .sample_out_o    (sample_out_o),
    .read_mode_o     (read_mode_o),
    .done_o          (done_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= TIMEOUT_CYCLES);
    $display("interpolated_ring_buffer_read_top_tb failed");
    $finish;
  end

  function automatic logic [CNT_W-1:0] valid_span();
    if (count_wrapped || written_count >= BUFFER_DEPTH) return BUFFER_DEPTH;
    return written_count;
  endfunction

  function automatic bit fetch_sample(input logic [CNT_W-1:0] pos, output longint val);
    logic [CNT_W-1:0]  back;
    logic [ADDR_W-1:0] slot;
    back = written_count - 32'd1 - pos;
    val = 0;
    if (back >= valid_span()) return 1'b0;
    slot = head_slot - ADDR_W'(1) - back[ADDR_W-1:0];
    val = longint'(sample_history[slot]);
    return 1'b1;
  endfunction

  function automatic void predict_history_access(input logic act,
                                                 input logic signed [SAMPLE_BITS-1:0] smp,
                                                 input logic [CNT_W-1:0] p,
                                                 input logic [FRAC_BITS-1:0] frac);
    history_result_t res;
    longint x, y0, y1, y2, y3, c1, c2, c3, t, acc;
    longint sat_hi, sat_lo;
    logic [CNT_W-1:0] rounded;
    bit interp, resolved;
    sat_hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    sat_lo = -sat_hi - 1;
    res.sample = '0;
    if (act == ACT_WRITE) begin
      sample_history[head_slot] = smp;
      head_slot = head_slot + 1'b1;
      written_count = written_count + 32'd1;
      if (written_count == '0) count_wrapped = 1'b1;
      res.mode = MODE_WRITE;
    end else begin
      x = longint'(frac);
      acc = 0;
      resolved = 1'b0;
      interp = (x != 0) && (100 * (ONE - x) > ONE);
      res.mode = MODE_INVALID;
      if (interp) begin
        if (fetch_sample(p - 32'd1, y0) && fetch_sample(p + 32'd2, y3) &&
            fetch_sample(p, y1) && fetch_sample(p + 32'd1, y2)) begin
          c1 = y2 - y0;
          c2 = 2 * y0 - 5 * y1 + 4 * y2 - y3;
          c3 = (y3 - y0) + 3 * (y1 - y2);
          t = (c3 * x + c2 * ONE) >>> FRAC_BITS;
          t = (t * x + c1 * ONE) >>> FRAC_BITS;
          t = t * x;
          acc = y1 + ((t + ONE) >>> (FRAC_BITS + 1));
          res.mode = MODE_CUBIC;
          resolved = 1'b1;
        end else if (fetch_sample(p, y1) && fetch_sample(p + 32'd1, y2)) begin
          acc = y1 + (((y2 - y1) * x + HALF) >>> FRAC_BITS);
          res.mode = MODE_LINEAR;
          resolved = 1'b1;
        end
      end
      if (!resolved) begin
        rounded = p + ((x >= HALF) ? 32'd1 : 32'd0);
        if (fetch_sample(rounded, y1)) begin
          acc = y1;
          res.mode = MODE_NEAREST;
        end else begin
          acc = 0;
          res.mode = MODE_INVALID;
        end
      end
      if (acc > sat_hi) acc = sat_hi;
      if (acc < sat_lo) acc = sat_lo;
      res.sample = acc[SAMPLE_BITS-1:0];
    end
    mode_hits[res.mode]++;
    predicted_results.push_back(res);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      results_seen <= results_seen + 1;
      if (predicted_results.size() == 0) begin
        $error("unexpected result: sample_out %0d, read_mode %0d", sample_out_o, read_mode_o);
        fail_count++;
      end else begin
        oldest_result = predicted_results.pop_front();
        if (sample_out_o !== oldest_result.sample) begin
          $error("sample_out: expected %0d, actual %0d", oldest_result.sample, sample_out_o);
          fail_count++;
        end
        if (read_mode_o !== oldest_result.mode) begin
          $error("read_mode: expected %0d, actual %0d", oldest_result.mode, read_mode_o);
          fail_count++;
        end
      end
    end
  end

  task automatic send_transaction(input logic act,
                                  input logic signed [SAMPLE_BITS-1:0] smp,
                                  input logic [CNT_W-1:0] whole,
                                  input logic [FRAC_BITS-1:0] frac);
    @(negedge clk_i);
    start            <= 1'b1;
    action_i         <= act;
    sample_in_i      <= smp;
    position_whole_i <= whole;
    position_frac_i  <= frac;
    do @(posedge clk_i); while (busy !== 1'b0);
    predict_history_access(act, smp, whole, frac);
  endtask

  task automatic hold_start_low();
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  task automatic await_all_results();
    hold_start_low();
    while (predicted_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_empty_history();
    send_transaction(ACT_READ, '0, '0, '0);
    send_transaction(ACT_READ, '1, '1, '1);
    send_transaction(ACT_READ, '0, '0, FRAC_BITS'(HALF));
  endtask

  // positions 0..5 hold overshoot patterns for both saturation directions
  task automatic test_sample_extremes();
    send_transaction(ACT_WRITE, SAMPLE_MIN, '1, '1);
    send_transaction(ACT_WRITE, SAMPLE_MAX, '0, '0);
    send_transaction(ACT_WRITE, SAMPLE_MAX, '1, '0);
    send_transaction(ACT_WRITE, SAMPLE_MIN, '0, '1);
    send_transaction(ACT_WRITE, SAMPLE_MIN, '1, '1);
    send_transaction(ACT_WRITE, SAMPLE_MAX, '0, '0);
    send_transaction(ACT_WRITE, 24'sh123456, '0, '0);
    send_transaction(ACT_WRITE, -24'sd1, '0, '0);
  endtask

  task automatic test_interpolation_modes();
    send_transaction(ACT_READ, '0, 32'd1, FRAC_BITS'(HALF));
    send_transaction(ACT_READ, '0, 32'd3, FRAC_BITS'(HALF));
    send_transaction(ACT_READ, '0, 32'd0, 16'h4000);
    send_transaction(ACT_READ, '0, 32'd6, 16'h1000);
    send_transaction(ACT_READ, '0, 32'd7, 16'h1000);
    send_transaction(ACT_READ, '0, 32'd7, FRAC_BITS'(HALF));
    send_transaction(ACT_READ, '0, 32'd2, '0);
    send_transaction(ACT_READ, '0, 32'd2, '1);
    send_transaction(ACT_READ, '0, 32'd2, FRAC_BITS'(LAST_INTERP_FRAC));
    send_transaction(ACT_READ, '0, 32'd2, FRAC_BITS'(LAST_INTERP_FRAC + 1));
    send_transaction(ACT_READ, '0, 32'd2, FRAC_BITS'(HALF - 1));
    send_transaction(ACT_READ, '0, 32'd5, 16'h0001);
    send_transaction(ACT_READ, '0, '1, '1);
    send_transaction(ACT_READ, '0, '1, FRAC_BITS'(HALF));
    send_transaction(ACT_READ, '0, 32'd100, '0);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int count);
    logic                          act;
    logic signed [SAMPLE_BITS-1:0] smp;
    logic [CNT_W-1:0]              whole, back, span;
    logic [FRAC_BITS-1:0]          frac;
    for (int i = 0; i < count; i++) begin
      while ($urandom_range(99) < idle_pct) hold_start_low();
      act  = ($urandom_range(99) >= 45) ? ACT_READ : ACT_WRITE;
      smp  = SAMPLE_BITS'($urandom);
      frac = FRAC_BITS'($urandom);
      span = valid_span();
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(3))
          0: smp = SAMPLE_MIN;
          1: smp = SAMPLE_MAX;
          2: smp = '0;
          default: smp = '1;
        endcase
      end
      case ($urandom_range(9))
        0, 1:          back = $urandom_range(6) - 3;
        2, 3:          back = span + $urandom_range(5) - 3;
        4, 5, 6, 7, 8: back = (span == 0) ? '0 : $urandom_range(span - 1);
        default:       back = $urandom;
      endcase
      whole = written_count - 32'd1 - back;
      if ($urandom_range(4) == 0) begin
        case ($urandom_range(6))
          0: frac = '0;
          1: frac = 16'd1;
          2: frac = FRAC_BITS'(HALF - 1);
          3: frac = FRAC_BITS'(HALF);
          4: frac = FRAC_BITS'(LAST_INTERP_FRAC);
          5: frac = FRAC_BITS'(LAST_INTERP_FRAC + 1);
          default: frac = '1;
        endcase
      end
      send_transaction(act, smp, whole, frac);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_history();
    test_sample_extremes();
    test_interpolation_modes();
    await_all_results();
    test_random_traffic(0, 150);
    await_all_results();
    test_random_traffic(85, 150);
    test_random_traffic(31, 150);
    await_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("checked %0d transactions, %0d of them appends", results_seen,
             mode_hits[MODE_WRITE]);
    $display("reads: nearest %0d, linear %0d, cubic %0d, invalid %0d; sender idle 0/85/31 pct",
             mode_hits[MODE_NEAREST], mode_hits[MODE_LINEAR], mode_hits[MODE_CUBIC],
             mode_hits[MODE_INVALID]);
    if (fail_count == 0) begin
      $display("interpolated_ring_buffer_read_top_tb passed");
    end else begin
      $display("interpolated_ring_buffer_read_top_tb failed");
    end
    $finish;
  end

endmodule
